// ----- rtl/core/assert_macros.svh -----
// Assertion helpers for the RTL; the planner top includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/tspp_pkg.sv -----
`default_nettype none
package tspp_pkg;

   localparam int CORDIC_STEPS = 20;
   localparam logic signed [32:0] CORDIC_START = 33'sd652032874;

   localparam logic [3:0] CSR_PPM_AB    = 4'd0;
   localparam logic [3:0] CSR_PPM_C     = 4'd1;
   localparam logic [3:0] CSR_SPD_FLOOR = 4'd2;
   localparam logic [3:0] CSR_SPD_CEIL  = 4'd3;
   localparam logic [3:0] CSR_ARM_ALONG = 4'd4;
   localparam logic [3:0] CSR_ARM_ACROSS = 4'd5;
   localparam logic [3:0] CSR_ANCHOR    = 4'd6;
   localparam logic [3:0] CSR_ROD       = 4'd7;

   localparam logic [9:0] RST_PPM_AB  = 10'd200;
   localparam logic [9:0] RST_PPM_C   = 10'd152;
   localparam logic [7:0] RST_FLOOR   = 8'd17;
   localparam logic [7:0] RST_CEIL    = 8'd30;
   localparam logic [9:0] RST_ALONG   = 10'd185;
   localparam logic [9:0] RST_ACROSS  = 10'd63;
   localparam logic [9:0] RST_ANCHOR  = 10'd100;
   localparam logic [9:0] RST_ROD     = 10'd356;

   localparam logic [14:0] STROKE_MAX = 15'd32767;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CORDIC,
      ST_TRIG,
      ST_SQ_U,
      ST_SQ_V,
      ST_ROOT_GO,
      ST_ROOT,
      ST_CHECK,
      ST_SCALE,
      ST_SUM,
      ST_SPEED_GO,
      ST_SPEED,
      ST_FINISH
   } state_type;

   // atan(2^-i) in 2^-16 degree
   function automatic logic [21:0] atan_val(input logic [4:0] i);
      logic [21:0] v;
      case (i)
         5'd0:  v = 22'd2949120;
         5'd1:  v = 22'd1740967;
         5'd2:  v = 22'd919879;
         5'd3:  v = 22'd466945;
         5'd4:  v = 22'd234379;
         5'd5:  v = 22'd117304;
         5'd6:  v = 22'd58666;
         5'd7:  v = 22'd29335;
         5'd8:  v = 22'd14668;
         5'd9:  v = 22'd7334;
         5'd10: v = 22'd3667;
         5'd11: v = 22'd1833;
         5'd12: v = 22'd917;
         5'd13: v = 22'd458;
         5'd14: v = 22'd229;
         5'd15: v = 22'd115;
         5'd16: v = 22'd57;
         5'd17: v = 22'd29;
         5'd18: v = 22'd14;
         5'd19: v = 22'd7;
         default: v = 22'd0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/core/tspp_if.sv -----
`default_nettype none
interface tspp_req_if;
   logic               valid;
   logic               ready;
   logic signed [14:0] pos_x;
   logic signed [14:0] pos_y;
   logic signed [12:0] angle;
   modport source (output valid, pos_x, pos_y, angle, input ready);
   modport sink (input valid, pos_x, pos_y, angle, output ready);
endinterface

interface tspp_rsp_if;
   logic        valid;
   logic        ready;
   logic [14:0] stroke_a;
   logic [14:0] stroke_b;
   logic [14:0] stroke_c;
   logic [7:0]  speed_a;
   logic [7:0]  speed_b;
   logic [7:0]  speed_c;
   logic        homing;
   modport source (output valid, stroke_a, stroke_b, stroke_c, speed_a, speed_b, speed_c,
                   homing, input ready);
   modport sink (input valid, stroke_a, stroke_b, stroke_c, speed_a, speed_b, speed_c,
                 homing, output ready);
endinterface

interface tspp_csr_if;
   logic       valid;
   logic       ready;
   logic [3:0] idx;
   logic [9:0] data;
   modport source (output valid, idx, data, input ready);
   modport sink (input valid, idx, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/tspp_cordic.sv -----
`default_nettype none
module tspp_cordic (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [25:0] z_init,
   input  wire logic               neg,
   output logic signed [31:0]      cos_o,
   output logic signed [31:0]      sin_o,
   output logic                    done
);
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [4:0]         i_ff, i_in;
   logic signed [32:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [25:0] z_ff, z_in;
   logic               neg_ff, neg_in;
   logic signed [32:0] dx, dy;
   logic signed [25:0] ang;

   assign dx  = cy_ff >>> i_ff;
   assign dy  = cx_ff >>> i_ff;
   assign ang = signed'({4'b0, tspp_pkg::atan_val(i_ff)});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      i_in    = i_ff;
      cx_in   = cx_ff;
      cy_in   = cy_ff;
      z_in    = z_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         i_in    = '0;
         cx_in   = tspp_pkg::CORDIC_START;
         cy_in   = '0;
         z_in    = z_init;
         neg_in  = neg;
      end else if (busy_ff) begin
         // rotate towards zero residual angle
         if (z_ff >= 0) begin
            cx_in = cx_ff - dx;
            cy_in = cy_ff + dy;
            z_in  = z_ff - ang;
         end else begin
            cx_in = cx_ff + dx;
            cy_in = cy_ff - dy;
            z_in  = z_ff + ang;
         end
         i_in = i_ff + 5'd1;
         if (i_ff == 5'(tspp_pkg::CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      i_ff   <= i_in;
      cx_ff  <= cx_in;
      cy_ff  <= cy_in;
      z_ff   <= z_in;
      neg_ff <= neg_in;
   end

   assign cos_o = neg_ff ? 32'(-cx_ff) : cx_ff[31:0];
   assign sin_o = neg_ff ? 32'(-cy_ff) : cy_ff[31:0];
   assign done  = done_ff;
endmodule
`default_nettype wire

// ----- rtl/core/tspp_isqrt.sv -----
`default_nettype none
module tspp_isqrt (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [57:0] radicand,
   output logic [28:0]      root,
   output logic             done
);
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [57:0] rad_ff, rad_in;
   logic [29:0] rem_ff, rem_in;
   logic [28:0] root_ff, root_in;
   logic [31:0] rem_sh, trial;

   assign rem_sh = {rem_ff, rad_ff[57:56]};
   assign trial  = {2'b0, root_ff[28:0], 1'b0} + 32'd0 + {1'b0, root_ff, 2'b01} - {2'b0, root_ff, 1'b0};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         // one result bit per cycle, two radicand bits in
         rad_in = {rad_ff[55:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = 30'(rem_sh - trial);
            root_in = {root_ff[27:0], 1'b1};
         end else begin
            rem_in  = rem_sh[29:0];
            root_in = {root_ff[27:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd28) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign root = root_ff;
   assign done = done_ff;
endmodule
`default_nettype wire

// ----- rtl/core/tspp_div.sv -----
`default_nettype none
module tspp_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [20:0] num,
   input  wire logic [16:0] den,
   output logic [7:0]       quot,
   output logic             done
);
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [20:0] rem_ff, rem_in;
   logic [24:0] dsh_ff, dsh_in;
   logic [7:0]  q_ff, q_in;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = num;
         dsh_in  = {1'b0, den, 7'b0};
         q_in    = '0;
      end else if (busy_ff) begin
         // restoring step, quotient bit from the top
         if ({4'b0, rem_ff} >= dsh_ff) begin
            rem_in = rem_ff - dsh_ff[20:0];
            q_in   = {q_ff[6:0], 1'b1};
         end else begin
            q_in = {q_ff[6:0], 1'b0};
         end
         dsh_in = {1'b0, dsh_ff[24:1]};
         cnt_in = cnt_ff + 3'd1;
         if (cnt_ff == 3'd7) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
   end

   assign quot = q_ff;
   assign done = done_ff;
endmodule
`default_nettype wire

// ----- rtl/core/three_strut_pose_to_stroke_planner_top.sv -----
`default_nettype none
// Pose to stroke planner for a three-strut planar platform. A request word
// carries x, y (1/16 mm) and a rotation (1/16 degree); the response word
// carries three saturated pulse strokes, three clamped speed references and
// a homing flag. One pose is worked at a time and req_ch.ready is low while
// it is in flight. A pose runs through the 20-step CORDIC, three 29-step
// square roots and three 8-step divisions, with one 32x32 multiplier
// shared by the trig, square and scaling products. A finished response
// sits in an output register, so the next pose may be taken while it
// waits. Registers are written through csr_ch (always ready); indexes
// beyond the list are dropped. Write them only while no pose is in flight.
`include "assert_macros.svh"
module three_strut_pose_to_stroke_planner_top (
   input  wire logic clock,
   input  wire logic reset,
   tspp_req_if.sink   req_ch,
   tspp_rsp_if.source rsp_ch,
   tspp_csr_if.sink   csr_ch
);
   tspp_pkg::state_type state_ff, state_in;

   // configuration
   logic [9:0] ppm_ab_ff, ppm_c_ff, along_ff, across_ff, anchor_ff, rod_ff;
   logic [7:0] floor_ff, ceil_ff;

   // carried state between poses
   logic [14:0] last_ff [3];
   logic [16:0] last_sum_ff;

   // working registers
   logic [2:0]         cnt_ff;
   logic [1:0]         idx_ff;
   logic signed [26:0] x_ff, y_ff;
   logic signed [29:0] as_ff, ac_ff, bs_ff, bc_ff;
   logic signed [63:0] prod_ff;
   logic [55:0]        usq_ff;
   logic [28:0]        len_ff [3];
   logic [14:0]        pulse_ff [3];
   logic [7:0]         speed_ff [3];
   logic               homing_ff;
   logic [16:0]        sum_ff;

   // response register
   logic        rsp_valid_ff;
   logic [14:0] out_stroke_ff [3];
   logic [7:0]  out_speed_ff [3];
   logic        out_homing_ff;

   // control strobes
   logic               cordic_start, sqrt_start, div_start;
   logic signed [31:0] mul_a, mul_b;
   logic               take_req, load_rsp;

   // sub-unit links
   logic signed [31:0] cos_w, sin_w;
   logic               cordic_done, sqrt_done, div_done;
   logic [28:0]        root_w;
   logic [7:0]         quot_w;

   // angle wrap and fold
   logic signed [13:0] ang0, ang1, ang2;
   logic               fold;
   logic signed [25:0] z_start;

   always_comb begin
      ang0 = 14'(req_ch.angle);
      ang1 = ang0;
      if (ang0 > 14'sd2880) ang1 = ang0 - 14'sd5760;
      if (ang1 < -14'sd2880) ang1 = ang1 + 14'sd5760;
      ang2 = ang1;
      fold = 1'b0;
      if (ang1 > 14'sd1440) begin
         ang2 = ang1 - 14'sd2880;
         fold = 1'b1;
      end
      if (ang2 < -14'sd1440) begin
         ang2 = ang2 + 14'sd2880;
         fold = 1'b1;
      end
      z_start = {ang2, 12'b0};
   end

   // joint vectors in 2^-16 mm
   logic signed [29:0] dd, u1, v1, u2, u3, v3, u_sel, v_sel;
   logic [28:0]        au, av;
   logic [25:0]        rod16;

   assign dd    = signed'({4'b0, anchor_ff, 16'b0});
   assign rod16 = {rod_ff, 16'b0};
   assign u1    = 30'(x_ff) + as_ff - bc_ff;
   assign v1    = 30'(y_ff) + ac_ff + bs_ff;
   assign u2    = u1 + dd;
   assign u3    = 30'(x_ff) + as_ff + bc_ff - dd;
   assign v3    = 30'(y_ff) + ac_ff - bs_ff;

   always_comb begin
      case (idx_ff)
         2'd0:    begin u_sel = u1; v_sel = v1; end
         2'd1:    begin u_sel = u2; v_sel = v1; end
         default: begin u_sel = u3; v_sel = v3; end
      endcase
      au = u_sel[29] ? 29'(-u_sel) : u_sel[28:0];
      av = v_sel[29] ? 29'(-v_sel) : v_sel[28:0];
   end

   // stroke above the rod, scaling index and rounding
   logic [1:0]  sidx, pidx;
   logic [28:0] len_s, stroke_s;
   logic [9:0]  ppm_s;
   logic [39:0] round_s;
   logic [19:0] pulse_raw;

   assign sidx      = cnt_ff[1:0];
   assign pidx      = 2'(cnt_ff - 3'd1);
   assign len_s     = len_ff[sidx];
   assign stroke_s  = (len_s > {3'b0, rod16}) ? (len_s - {3'b0, rod16}) : '0;
   assign ppm_s     = (sidx == 2'd2) ? ppm_c_ff : ppm_ab_ff;
   assign round_s   = prod_ff[39:0] + 40'h8_0000;
   assign pulse_raw = round_s[39:20];

   logic signed [63:0] trig_rnd;
   logic signed [29:0] trig_mm;
   assign trig_rnd = prod_ff + 64'sd8192;
   assign trig_mm  = trig_rnd[43:14];

   logic homing_now;
   assign homing_now = (len_ff[0] <= {3'b0, rod16}) && (len_ff[1] <= {3'b0, rod16})
                       && (len_ff[2] <= {3'b0, rod16});

   // speed numerator ceil(60*p/sum)
   logic [14:0] spd_src;
   logic [20:0] num60;
   logic [7:0]  raw_spd, clamp_spd;
   assign spd_src = homing_ff ? last_ff[idx_ff] : pulse_ff[idx_ff];
   assign num60   = {spd_src, 6'b0} - {4'b0, spd_src, 2'b0} + {4'b0, sum_ff} - 21'd1;
   assign raw_spd = (sum_ff == '0) ? 8'd0 : quot_w;

   always_comb begin
      if (raw_spd > ceil_ff)       clamp_spd = ceil_ff;
      else if (raw_spd < floor_ff) clamp_spd = floor_ff;
      else                         clamp_spd = raw_spd;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tspp_pkg::ST_IDLE:     if (req_ch.valid) state_in = tspp_pkg::ST_CORDIC;
         tspp_pkg::ST_CORDIC:   if (cordic_done) state_in = tspp_pkg::ST_TRIG;
         tspp_pkg::ST_TRIG:     if (cnt_ff == 3'd4) state_in = tspp_pkg::ST_SQ_U;
         tspp_pkg::ST_SQ_U:     state_in = tspp_pkg::ST_SQ_V;
         tspp_pkg::ST_SQ_V:     state_in = tspp_pkg::ST_ROOT_GO;
         tspp_pkg::ST_ROOT_GO:  state_in = tspp_pkg::ST_ROOT;
         tspp_pkg::ST_ROOT: begin
            if (sqrt_done)
               state_in = (idx_ff == 2'd2) ? tspp_pkg::ST_CHECK : tspp_pkg::ST_SQ_U;
         end
         tspp_pkg::ST_CHECK:
            state_in = homing_now ? tspp_pkg::ST_SUM : tspp_pkg::ST_SCALE;
         tspp_pkg::ST_SCALE:    if (cnt_ff == 3'd3) state_in = tspp_pkg::ST_SUM;
         tspp_pkg::ST_SUM:      state_in = tspp_pkg::ST_SPEED_GO;
         tspp_pkg::ST_SPEED_GO: state_in = tspp_pkg::ST_SPEED;
         tspp_pkg::ST_SPEED: begin
            if (div_done)
               state_in = (idx_ff == 2'd2) ? tspp_pkg::ST_FINISH : tspp_pkg::ST_SPEED_GO;
         end
         tspp_pkg::ST_FINISH:
            if (!rsp_valid_ff || rsp_ch.ready) state_in = tspp_pkg::ST_IDLE;
         default:               state_in = tspp_pkg::ST_IDLE;
      endcase
   end

   // control outputs and multiplier operands
   always_comb begin
      req_ch.ready = 1'b0;
      cordic_start = 1'b0;
      sqrt_start   = 1'b0;
      div_start    = 1'b0;
      load_rsp     = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      case (state_ff)
         tspp_pkg::ST_IDLE: begin
            req_ch.ready = 1'b1;
            cordic_start = req_ch.valid;
         end
         tspp_pkg::ST_TRIG: begin
            mul_a = signed'({22'b0, cnt_ff[1] ? across_ff : along_ff});
            mul_b = cnt_ff[0] ? cos_w : sin_w;
         end
         tspp_pkg::ST_SQ_U: begin
            mul_a = signed'({3'b0, au});
            mul_b = signed'({3'b0, au});
         end
         tspp_pkg::ST_SQ_V: begin
            mul_a = signed'({3'b0, av});
            mul_b = signed'({3'b0, av});
         end
         tspp_pkg::ST_ROOT_GO:  sqrt_start = 1'b1;
         tspp_pkg::ST_SCALE: begin
            mul_a = signed'({3'b0, stroke_s});
            mul_b = signed'({22'b0, ppm_s});
         end
         tspp_pkg::ST_SPEED_GO: div_start = 1'b1;
         tspp_pkg::ST_FINISH:   load_rsp = !rsp_valid_ff || rsp_ch.ready;
         default: ;
      endcase
   end

   assign take_req = req_ch.valid && req_ch.ready;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tspp_pkg::ST_IDLE;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         ppm_ab_ff    <= tspp_pkg::RST_PPM_AB;
         ppm_c_ff     <= tspp_pkg::RST_PPM_C;
         floor_ff     <= tspp_pkg::RST_FLOOR;
         ceil_ff      <= tspp_pkg::RST_CEIL;
         along_ff     <= tspp_pkg::RST_ALONG;
         across_ff    <= tspp_pkg::RST_ACROSS;
         anchor_ff    <= tspp_pkg::RST_ANCHOR;
         rod_ff       <= tspp_pkg::RST_ROD;
         last_ff[0]   <= '0;
         last_ff[1]   <= '0;
         last_ff[2]   <= '0;
         last_sum_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_ch.valid) begin
            case (csr_ch.idx)
               tspp_pkg::CSR_PPM_AB:     ppm_ab_ff <= csr_ch.data;
               tspp_pkg::CSR_PPM_C:      ppm_c_ff  <= csr_ch.data;
               tspp_pkg::CSR_SPD_FLOOR:  floor_ff  <= csr_ch.data[7:0];
               tspp_pkg::CSR_SPD_CEIL:   ceil_ff   <= csr_ch.data[7:0];
               tspp_pkg::CSR_ARM_ALONG:  along_ff  <= csr_ch.data;
               tspp_pkg::CSR_ARM_ACROSS: across_ff <= csr_ch.data;
               tspp_pkg::CSR_ANCHOR:     anchor_ff <= csr_ch.data;
               tspp_pkg::CSR_ROD:        rod_ff    <= csr_ch.data;
               default: ;
            endcase
         end
         // step counters
         case (state_ff)
            tspp_pkg::ST_CORDIC: cnt_ff <= '0;
            tspp_pkg::ST_TRIG:   if (cnt_ff == 3'd4) idx_ff <= '0; else cnt_ff <= cnt_ff + 3'd1;
            tspp_pkg::ST_ROOT:   if (sqrt_done) idx_ff <= idx_ff + 2'd1;
            tspp_pkg::ST_CHECK:  cnt_ff <= '0;
            tspp_pkg::ST_SCALE:  cnt_ff <= cnt_ff + 3'd1;
            tspp_pkg::ST_SUM:    idx_ff <= '0;
            tspp_pkg::ST_SPEED:  if (div_done) idx_ff <= idx_ff + 2'd1;
            default: ;
         endcase
         // drop the response on hand-off, load the new one
         if (load_rsp) rsp_valid_ff <= 1'b1;
         else if (rsp_ch.ready) rsp_valid_ff <= 1'b0;
         // advance the carried state with the response
         if (load_rsp) begin
            for (int k = 0; k < 3; k++)
               last_ff[k] <= homing_ff ? 15'd0 : pulse_ff[k];
            if (!homing_ff) last_sum_ff <= sum_ff;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (take_req) begin
         x_ff <= {req_ch.pos_x, 12'b0};
         y_ff <= {req_ch.pos_y, 12'b0};
      end
      case (state_ff)
         tspp_pkg::ST_TRIG: begin
            case (cnt_ff)
               3'd1:    as_ff <= trig_mm;
               3'd2:    ac_ff <= trig_mm;
               3'd3:    bs_ff <= trig_mm;
               3'd4:    bc_ff <= trig_mm;
               default: ;
            endcase
         end
         tspp_pkg::ST_SQ_V: usq_ff <= prod_ff[55:0];
         tspp_pkg::ST_ROOT: if (sqrt_done) len_ff[idx_ff] <= root_w;
         tspp_pkg::ST_CHECK: begin
            homing_ff <= homing_now;
            if (homing_now) begin
               pulse_ff[0] <= '0;
               pulse_ff[1] <= '0;
               pulse_ff[2] <= '0;
            end
         end
         tspp_pkg::ST_SCALE: begin
            if (cnt_ff != 3'd0)
               pulse_ff[pidx] <= (pulse_raw > 20'(tspp_pkg::STROKE_MAX)) ?
                                 tspp_pkg::STROKE_MAX : pulse_raw[14:0];
         end
         tspp_pkg::ST_SUM:
            sum_ff <= homing_ff ? last_sum_ff :
                      17'(pulse_ff[0]) + 17'(pulse_ff[1]) + 17'(pulse_ff[2]);
         tspp_pkg::ST_SPEED: if (div_done) speed_ff[idx_ff] <= clamp_spd;
         default: ;
      endcase
      if (load_rsp) begin
         for (int k = 0; k < 3; k++) begin
            out_stroke_ff[k] <= pulse_ff[k];
            out_speed_ff[k]  <= speed_ff[k];
         end
         out_homing_ff <= homing_ff;
      end
   end

   tspp_cordic u_cordic (
      .clock  (clock),
      .reset  (reset),
      .start  (cordic_start),
      .z_init (z_start),
      .neg    (fold),
      .cos_o  (cos_w),
      .sin_o  (sin_w),
      .done   (cordic_done)
   );

   tspp_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand ({2'b0, usq_ff} + {2'b0, prod_ff[55:0]}),
      .root     (root_w),
      .done     (sqrt_done)
   );

   tspp_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num60),
      .den   (sum_ff),
      .quot  (quot_w),
      .done  (div_done)
   );

   assign csr_ch.ready    = 1'b1;
   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.stroke_a = out_stroke_ff[0];
   assign rsp_ch.stroke_b = out_stroke_ff[1];
   assign rsp_ch.stroke_c = out_stroke_ff[2];
   assign rsp_ch.speed_a  = out_speed_ff[0];
   assign rsp_ch.speed_b  = out_speed_ff[1];
   assign rsp_ch.speed_c  = out_speed_ff[2];
   assign rsp_ch.homing   = out_homing_ff;

   `ASSERT_IMP(a_req_only_idle, clock, reset, req_ch.valid && req_ch.ready, state_ff == tspp_pkg::ST_IDLE, "pose taken while busy")
   `ASSERT_IMP(a_homing_zero, clock, reset, rsp_ch.valid && rsp_ch.homing, (rsp_ch.stroke_a == 15'd0) && (rsp_ch.stroke_b == 15'd0) && (rsp_ch.stroke_c == 15'd0), "homing word with nonzero stroke")
   `ASSERT_IMP(a_speed_range, clock, reset, rsp_ch.valid && (floor_ff <= ceil_ff), (rsp_ch.speed_a >= floor_ff) && (rsp_ch.speed_a <= ceil_ff), "speed outside limits")
   `ASSERT_NEXT(a_load_valid, clock, reset, load_rsp, rsp_valid_ff, "response lost on load")
endmodule
`default_nettype wire

// ----- dv/three_strut_pose_to_stroke_planner_top_test.sv -----
`default_nettype none
module three_strut_pose_to_stroke_planner_top_test;

   typedef struct {
      logic signed [14:0] x;
      logic signed [14:0] y;
      logic signed [12:0] ang;
   } pose_type;

   typedef struct {
      logic [14:0] stroke_a;
      logic [14:0] stroke_b;
      logic [14:0] stroke_c;
      logic [7:0]  speed_a;
      logic [7:0]  speed_b;
      logic [7:0]  speed_c;
      logic        homing;
   } move_type;

   // Index past the end of the register list; writes to it must be dropped.
   localparam logic [3:0] CSR_SPARE = 4'd12;
   localparam int         IDLE_LIMIT = 20000;
   localparam int         HOLD_CYCLES = 700;

   localparam longint ATAN_TAB [20] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
   };

   logic clock;
   logic reset;

   tspp_req_if req_ch ();
   tspp_rsp_if rsp_ch ();
   tspp_csr_if csr_ch ();

   three_strut_pose_to_stroke_planner_top u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source),
      .csr_ch (csr_ch.sink)
   );

   // Our own copy of the register file and the remembered move.
   logic [9:0]  ppm_ab, ppm_c, arm_along, arm_across, anchor, rod;
   logic [7:0]  spd_floor, spd_ceil;
   longint      prev_a, prev_b, prev_c, prev_sum;

   pose_type pose_q [$];
   move_type move_q [$];
   pose_type held;

   int  mismatches = 0;
   bit  calm = 0;        // no idling on either side while set
   bit  hold_ask = 0;    // ask the receiver for one long hold-off
   bit  hold_done = 0;
   int  hold_cnt = 0;
   int  idle_cnt = 0;

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------
   function automatic longint root_of(longint v);
      longint r, b;
      r = 0;
      b = 64'sh4000_0000_0000_0000;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint length_of(longint u, longint v);
      longint au, av;
      au = (u < 0) ? -u : u;
      av = (v < 0) ? -v : v;
      return root_of(au * au + av * av);
   endfunction

   function automatic longint pulses_of(longint len, longint ppm);
      longint s, p;
      s = (len > (longint'(rod) << 16)) ? len - (longint'(rod) << 16) : 0;
      p = (s * ppm + (longint'(1) << 19)) >> 20;
      return (p > 32767) ? 32767 : p;
   endfunction

   function automatic logic [7:0] speed_ref(longint p, longint sum);
      longint raw;
      raw = 0;
      if (sum != 0) raw = (60 * p + sum - 1) / sum;
      if (raw > longint'(spd_ceil)) return spd_ceil;
      if (raw < longint'(spd_floor)) return spd_floor;
      return raw[7:0];
   endfunction

   function automatic move_type plan_move(pose_type p);
      move_type m;
      longint px, py, a, cx, cy, z, dx, dy;
      longint as_, ac_, bs_, bc_, d, u1, v1, u3, v3, l1, l2, l3, rl;
      longint pa, pb, pc, sum;
      bit     flip;
      px = longint'(p.x) * 4096;
      py = longint'(p.y) * 4096;
      a = longint'(p.ang);
      flip = 0;
      if (a > 2880) a -= 5760;
      if (a < -2880) a += 5760;
      if (a > 1440) begin a -= 2880; flip = 1; end
      if (a < -1440) begin a += 2880; flip = 1; end
      z = a * 4096;
      cx = 652032874;
      cy = 0;
      for (int i = 0; i < 20; i++) begin
         dx = cy >>> i;
         dy = cx >>> i;
         if (z >= 0) begin
            cx -= dx; cy += dy; z -= ATAN_TAB[i];
         end else begin
            cx += dx; cy -= dy; z += ATAN_TAB[i];
         end
      end
      if (flip) begin cx = -cx; cy = -cy; end
      as_ = (longint'(arm_along) * cy + 8192) >>> 14;
      ac_ = (longint'(arm_along) * cx + 8192) >>> 14;
      bs_ = (longint'(arm_across) * cy + 8192) >>> 14;
      bc_ = (longint'(arm_across) * cx + 8192) >>> 14;
      d = longint'(anchor) << 16;
      u1 = px + as_ - bc_;
      v1 = py + ac_ + bs_;
      u3 = px + as_ + bc_ - d;
      v3 = py + ac_ - bs_;
      l1 = length_of(u1, v1);
      l2 = length_of(u1 + d, v1);
      l3 = length_of(u3, v3);
      rl = longint'(rod) << 16;
      if (l1 <= rl && l2 <= rl && l3 <= rl) begin
         // homing: speeds from the remembered move, remembered sum kept
         m.stroke_a = '0; m.stroke_b = '0; m.stroke_c = '0;
         m.speed_a = speed_ref(prev_a, prev_sum);
         m.speed_b = speed_ref(prev_b, prev_sum);
         m.speed_c = speed_ref(prev_c, prev_sum);
         m.homing = 1'b1;
         prev_a = 0; prev_b = 0; prev_c = 0;
         return m;
      end
      pa = pulses_of(l1, longint'(ppm_ab));
      pb = pulses_of(l2, longint'(ppm_ab));
      pc = pulses_of(l3, longint'(ppm_c));
      sum = pa + pb + pc;
      m.stroke_a = pa[14:0]; m.stroke_b = pb[14:0]; m.stroke_c = pc[14:0];
      m.speed_a = speed_ref(pa, sum);
      m.speed_b = speed_ref(pb, sum);
      m.speed_c = speed_ref(pc, sum);
      m.homing = 1'b0;
      prev_a = pa; prev_b = pb; prev_c = pc; prev_sum = sum;
      return m;
   endfunction

   // ---------------------------------------------------------------------
   // Pose driver: offer queued poses, predict on acceptance
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            move_q.push_back(plan_move(held));
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (pose_q.size() > 0 && (calm || $urandom_range(99) >= 6)) begin
               held = pose_q.pop_front();
               req_ch.valid <= 1'b1;
               req_ch.pos_x <= held.x;
               req_ch.pos_y <= held.y;
               req_ch.angle <= held.ang;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response monitor: random back-pressure, one long hold-off on request
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      move_type m;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (move_q.size() == 0) begin
               $error("response word with no pose outstanding");
               mismatches++;
            end else begin
               m = move_q.pop_front();
               if (rsp_ch.stroke_a !== m.stroke_a) begin
                  $error("stroke_a expected %0d got %0d", m.stroke_a, rsp_ch.stroke_a);
                  mismatches++;
               end
               if (rsp_ch.stroke_b !== m.stroke_b) begin
                  $error("stroke_b expected %0d got %0d", m.stroke_b, rsp_ch.stroke_b);
                  mismatches++;
               end
               if (rsp_ch.stroke_c !== m.stroke_c) begin
                  $error("stroke_c expected %0d got %0d", m.stroke_c, rsp_ch.stroke_c);
                  mismatches++;
               end
               if (rsp_ch.speed_a !== m.speed_a) begin
                  $error("speed_a expected %0d got %0d", m.speed_a, rsp_ch.speed_a);
                  mismatches++;
               end
               if (rsp_ch.speed_b !== m.speed_b) begin
                  $error("speed_b expected %0d got %0d", m.speed_b, rsp_ch.speed_b);
                  mismatches++;
               end
               if (rsp_ch.speed_c !== m.speed_c) begin
                  $error("speed_c expected %0d got %0d", m.speed_c, rsp_ch.speed_c);
                  mismatches++;
               end
               if (rsp_ch.homing !== m.homing) begin
                  $error("homing expected %0d got %0d", m.homing, rsp_ch.homing);
                  mismatches++;
               end
            end
         end
         if (hold_ask && !hold_done) begin
            rsp_ch.ready <= 1'b0;
            hold_cnt++;
            if (hold_cnt >= HOLD_CYCLES) hold_done = 1;
         end else begin
            rsp_ch.ready <= calm || ($urandom_range(99) >= 6);
         end
      end
   end

   // Watchdog: count cycles in which no word moves on any channel.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready)) begin
         idle_cnt = 0;
      end else begin
         idle_cnt++;
         if (idle_cnt >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sequencing
   // ---------------------------------------------------------------------
   task automatic write_reg(logic [3:0] idx, logic [9:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.idx   <= idx;
      csr_ch.data  <= data;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      // mirror the write; narrow registers keep their low bits
      case (idx)
         tspp_pkg::CSR_PPM_AB:     ppm_ab = data;
         tspp_pkg::CSR_PPM_C:      ppm_c = data;
         tspp_pkg::CSR_SPD_FLOOR:  spd_floor = data[7:0];
         tspp_pkg::CSR_SPD_CEIL:   spd_ceil = data[7:0];
         tspp_pkg::CSR_ARM_ALONG:  arm_along = data;
         tspp_pkg::CSR_ARM_ACROSS: arm_across = data;
         tspp_pkg::CSR_ANCHOR:     anchor = data;
         tspp_pkg::CSR_ROD:        rod = data;
         default: ;
      endcase
   endtask

   task automatic write_all(logic [9:0] pa, logic [9:0] pc, logic [9:0] fl, logic [9:0] cl,
                            logic [9:0] al, logic [9:0] ac, logic [9:0] an, logic [9:0] rd);
      write_reg(tspp_pkg::CSR_PPM_AB, pa);
      write_reg(tspp_pkg::CSR_PPM_C, pc);
      write_reg(tspp_pkg::CSR_SPD_FLOOR, fl);
      write_reg(tspp_pkg::CSR_SPD_CEIL, cl);
      write_reg(tspp_pkg::CSR_ARM_ALONG, al);
      write_reg(tspp_pkg::CSR_ARM_ACROSS, ac);
      write_reg(tspp_pkg::CSR_ANCHOR, an);
      write_reg(tspp_pkg::CSR_ROD, rd);
   endtask

   task automatic add_pose(int x, int y, int ang);
      pose_type p;
      p.x = 15'(x);
      p.y = 15'(y);
      p.ang = 13'(ang);
      pose_q.push_back(p);
   endtask

   // Mostly full-range poses, a share near the origin to hit homing runs,
   // and some corner values.
   task automatic add_random(int n);
      int k;
      repeat (n) begin
         k = $urandom_range(9);
         if (k < 3)
            add_pose($urandom_range(8000) - 4000, $urandom_range(8000) - 4000,
                     $urandom_range(5760) - 2880);
         else if (k < 8)
            add_pose($urandom_range(32767) - 16384, $urandom_range(32767) - 16384,
                     $urandom_range(5760) - 2880);
         else
            add_pose($urandom_range(1) ? 16383 : -16384, $urandom_range(1) ? 16383 : -16384,
                     $urandom_range(1) ? 2880 : -2880);
      end
   endtask

   // Hold until every queued pose is taken and every response has come.
   task automatic drain();
      @(posedge clock);
      while (pose_q.size() != 0 || req_ch.valid || move_q.size() != 0) @(posedge clock);
   endtask

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.pos_x = '0;
      req_ch.pos_y = '0;
      req_ch.angle = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.idx = '0;
      csr_ch.data = '0;
      ppm_ab = tspp_pkg::RST_PPM_AB; ppm_c = tspp_pkg::RST_PPM_C;
      spd_floor = tspp_pkg::RST_FLOOR; spd_ceil = tspp_pkg::RST_CEIL;
      arm_along = tspp_pkg::RST_ALONG; arm_across = tspp_pkg::RST_ACROSS;
      anchor = tspp_pkg::RST_ANCHOR; rod = tspp_pkg::RST_ROD;
      prev_a = 0; prev_b = 0; prev_c = 0; prev_sum = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: homing from a clean state, angle folding and wrap
      // edges, corners of the pose field, then homing after a real move.
      add_pose(0, 0, 0);
      add_pose(16383, 16383, 2880);
      add_pose(-16384, -16384, -2880);
      add_pose(16383, -16384, 1441);
      add_pose(-16384, 16383, -1441);
      add_pose(0, 0, 1440);
      add_pose(0, 0, -1440);
      add_pose(4000, 0, 0);
      add_pose(0, 0, 0);
      add_pose(0, 0, 0);
      add_pose(3000, 5000, 720);
      add_pose(-8000, 9000, -2000);
      add_pose(16383, 0, 2048);
      add_pose(0, 16383, -1);
      add_pose(-1, -1, 1);
      add_pose(-16384, 0, 2880);
      add_pose(0, -16384, -2880);
      add_random(110);
      drain();

      // Every register at its top value; the receiver holds off long enough
      // to back the block up while poses keep coming.
      write_all(10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023,
                10'd1023, 10'd1023);
      hold_ask = 1;
      add_random(110);
      drain();

      // All geometry zero: origin poses home, everything else has zero pulses
      // and so a zero sum. No idling on either side here.
      write_all(10'd0, 10'd0, 10'd9, 10'd200, 10'd0, 10'd0, 10'd0, 10'd0);
      calm = 1;
      add_pose(0, 0, 0);
      add_random(100);
      drain();
      calm = 0;

      // Floor above ceiling; a write to an unused index must change nothing.
      write_all(10'd200, 10'd152, 10'd200, 10'd20, 10'd185, 10'd63, 10'd100, 10'd356);
      write_reg(CSR_SPARE, 10'h3ff);
      add_random(110);
      drain();

      repeat (4) begin
         write_all(10'($urandom_range(1023)), 10'($urandom_range(1023)),
                   10'($urandom_range(1023)), 10'($urandom_range(1023)),
                   10'($urandom_range(1023)), 10'($urandom_range(1023)),
                   10'($urandom_range(1023)), 10'($urandom_range(1023)));
         add_random(105);
         drain();
      end

      repeat (400) @(posedge clock);
      if (mismatches == 0 && move_q.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ----- sim.f -----
+incdir+rtl/core
rtl/core/tspp_pkg.sv
rtl/core/tspp_if.sv
rtl/core/tspp_cordic.sv
rtl/core/tspp_isqrt.sv
rtl/core/tspp_div.sv
rtl/core/three_strut_pose_to_stroke_planner_top.sv
dv/three_strut_pose_to_stroke_planner_top_test.sv
